// ===== src/sfr_pkg.sv =====
// sfr_pkg: shared types and constants of the streaming find and replace block
// used by stream_find_replace and sfr_out; no dependencies

package sfr_pkg;

  // configuration port geometry
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_BYTES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LEN   = 2'd3;

  // output sideband bit positions
  localparam int TUSER_W          = 2;
  localparam int TUSER_BYTE_VALID = 0;
  localparam int TUSER_DONE       = 1;

  // control that travels with one output run
  typedef struct packed {
    logic done;   // run closes the string
    logic empty;  // run is the single empty end marker
  } run_ctl_t;

endpackage

// ===== src/sfr_match.sv =====
// sfr_match: parallel prefix checks of the pending window against the pattern
// no package dependencies; instantiated by stream_find_replace

module sfr_match #(
  parameter int PATTERN_MAX = 8,
  parameter int CNT_W       = 4
) (
  input  logic [PATTERN_MAX-1:0][7:0] win,       // window with new byte appended
  input  logic [CNT_W-1:0]            cnt_app,   // bytes in that window
  input  logic [CNT_W-1:0]            plen,      // effective pattern length
  input  logic [63:0]                 pat_bytes,
  output logic                        full_hit,
  output logic [CNT_W-1:0]            rel        // leading bytes to release
);

  logic [PATTERN_MAX-1:0][PATTERN_MAX-1:0] eq;
  logic [PATTERN_MAX-1:0]                  ok;

  // byte compare matrix: window position i against pattern position j
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
        eq[i][j] = (win[i] == pat_bytes[8*j +: 8]);
      end
    end
  end

  // whole window equals the whole pattern
  always_comb begin
    full_hit = (plen != '0) && (cnt_app == plen);
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if ((CNT_W'(i) < plen) && !eq[i][i]) begin
        full_hit = 1'b0;
      end
    end
  end

  // tail starting at k is a proper prefix of the pattern
  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      ok[k] = (CNT_W'(k) < cnt_app) && ((cnt_app - CNT_W'(k)) < plen);
      for (int i = k; i < PATTERN_MAX; i++) begin
        if ((CNT_W'(i) < cnt_app) && !eq[i][i-k]) begin
          ok[k] = 1'b0;
        end
      end
    end
  end

  // smallest release that leaves a prefix, else release everything
  always_comb begin
    rel = cnt_app;
    for (int k = PATTERN_MAX - 1; k >= 0; k--) begin
      if (ok[k]) begin
        rel = CNT_W'(k);
      end
    end
  end

endmodule

// ===== src/sfr_out.sv =====
// sfr_out: result register that holds one run of output bytes and sends it
// one beat at a time; depends on sfr_pkg

module sfr_out
  import sfr_pkg::*;
#(
  parameter int RUN_MAX = 8,
  parameter int RUN_W   = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  logic [RUN_MAX-1:0][7:0]  load_bytes,
  input  logic [RUN_W-1:0]         load_len,
  input  run_ctl_t                 load_ctl,
  output logic                     run_free,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [7:0]               out_tdata,   // out_byte
  output logic                     out_tlast,   // last_of_run
  output logic [TUSER_W-1:0]       out_tuser    // byte_valid, string_done
);

  logic                    vld_r, vld_nxt;
  logic [RUN_MAX-1:0][7:0] bytes_r, bytes_nxt;
  logic [RUN_W-1:0]        rem_r, rem_nxt;
  run_ctl_t                ctl_r, ctl_nxt;
  logic                    last;
  logic                    fire;

  assign last     = (rem_r == RUN_W'(1));
  assign fire     = vld_r && out_tready;
  assign run_free = !vld_r || (fire && last);

  // advance through the run, reload when a new run arrives
  always_comb begin
    vld_nxt   = vld_r;
    bytes_nxt = bytes_r;
    rem_nxt   = rem_r;
    ctl_nxt   = ctl_r;
    if (fire) begin
      if (last) begin
        vld_nxt = 1'b0;
      end else begin
        bytes_nxt = bytes_r >> 8;
        rem_nxt   = rem_r - RUN_W'(1);
      end
    end
    if (load) begin
      vld_nxt   = 1'b1;
      bytes_nxt = load_bytes;
      rem_nxt   = load_len;
      ctl_nxt   = load_ctl;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      rem_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      rem_r <= rem_nxt;
    end
  end

  // run payload
  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    ctl_r   <= ctl_nxt;
  end

  // beat fields
  always_comb begin
    out_tvalid                  = vld_r;
    out_tdata                   = bytes_r[0];
    out_tlast                   = last;
    out_tuser                   = '0;
    out_tuser[TUSER_BYTE_VALID] = !ctl_r.empty;
    out_tuser[TUSER_DONE]       = ctl_r.done && last;
  end

endmodule

// ===== src/stream_find_replace.sv =====
// stream_find_replace: top level of the streaming find and replace block
// depends on sfr_pkg, sfr_match and sfr_out

// Replaces every leftmost, non-overlapping occurrence of the configured pattern
// (pattern_len bytes, at most PATTERN_MAX) in the byte stream with the configured
// replacement (replace_len bytes, at most REPLACE_MAX); other bytes pass through.
// A pattern length of zero passes all data unchanged. Input beats carry one byte,
// with in_tlast on the final byte of a string. Each input byte yields a run of
// zero to max(PATTERN_MAX, REPLACE_MAX) output beats; out_tlast marks the end of
// the run, and the final byte of a string always yields at least one beat (an
// empty marker with byte_valid low if nothing else is due) whose string_done is
// set. An accepted byte waits in the input register, where it is matched, until
// the output register is free and takes its run; the block takes one byte per
// cycle as long as each run leaves in a single beat, and a longer run holds the
// output register, and thus the input after one buffered byte, until its last
// beat is taken. Configure only while no string is in flight.

module stream_find_replace
  import sfr_pkg::*;
#(
  parameter int PATTERN_MAX = 8,
  parameter int REPLACE_MAX = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,    // in_byte
  input  logic                  in_tlast,    // end_of_string
  // output stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,   // out_byte
  output logic                  out_tlast,   // last_of_run
  output logic [TUSER_W-1:0]    out_tuser    // byte_valid, string_done
);

  localparam int CNT_W   = $clog2(PATTERN_MAX + 1);
  localparam int RUN_MAX = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;
  localparam int RUN_W   = $clog2(RUN_MAX + 1);

  // configuration registers
  logic [63:0] pat_bytes_r;
  logic [3:0]  pat_len_r;
  logic [63:0] rep_bytes_r;
  logic [3:0]  rep_len_r;

  // input register
  logic       item_vld_r, item_vld_nxt;
  logic [7:0] item_byte_r;
  logic       item_eos_r;

  // pending window
  logic [PATTERN_MAX-1:0][7:0] win_r, win_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;

  logic                        accept;
  logic                        advance;
  logic                        run_free;
  logic [CNT_W-1:0]            plen;
  logic [RUN_W-1:0]            rlen;
  logic [PATTERN_MAX-1:0][7:0] win_app;
  logic [CNT_W-1:0]            cnt_app;
  logic                        full_hit;
  logic [CNT_W-1:0]            rel;
  logic [RUN_MAX-1:0][7:0]     run_bytes;
  logic [RUN_W-1:0]            run_len;
  run_ctl_t                    run_ctl;
  logic                        run_load;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_bytes_r <= '0;
      pat_len_r   <= '0;
      rep_bytes_r <= '0;
      rep_len_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PATTERN_BYTES: pat_bytes_r <= cfg_wdata[63:0];
        CFG_PATTERN_LEN:   pat_len_r   <= cfg_wdata[3:0];
        CFG_REPLACE_BYTES: rep_bytes_r <= cfg_wdata[63:0];
        CFG_REPLACE_LEN:   rep_len_r   <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // oversized lengths saturate at the build limits
  assign plen = (pat_len_r > 4'(PATTERN_MAX)) ? CNT_W'(PATTERN_MAX) : CNT_W'(pat_len_r);
  assign rlen = (rep_len_r > 4'(REPLACE_MAX)) ? RUN_W'(REPLACE_MAX) : RUN_W'(rep_len_r);

  // input handshake: buffer one beat while the output run drains
  assign in_tready    = !item_vld_r || run_free;
  assign accept       = in_tvalid && in_tready;
  assign advance      = item_vld_r && run_free;
  assign item_vld_nxt = accept || (item_vld_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_byte_r <= in_tdata;
      item_eos_r  <= in_tlast;
    end
  end

  // append the new byte behind the pending bytes
  assign cnt_app = cnt_r + CNT_W'(1);

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      win_app[i] = (CNT_W'(i) == cnt_r) ? item_byte_r : win_r[i];
    end
  end

  sfr_match #(
    .PATTERN_MAX (PATTERN_MAX),
    .CNT_W       (CNT_W)
  ) u_match (
    .win       (win_app),
    .cnt_app   (cnt_app),
    .plen      (plen),
    .pat_bytes (pat_bytes_r),
    .full_hit  (full_hit),
    .rel       (rel)
  );

  // build the run for this byte and the window that stays behind
  always_comb begin
    run_bytes = '0;
    run_len   = '0;
    if (full_hit) begin
      for (int i = 0; i < RUN_MAX; i++) begin
        run_bytes[i] = rep_bytes_r[8*i +: 8];
      end
      run_len = rlen;
    end else begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        run_bytes[i] = win_app[i];
      end
      run_len = item_eos_r ? RUN_W'(cnt_app) : RUN_W'(rel);
    end

    // end of string with nothing to send: one empty marker
    run_ctl.done  = item_eos_r;
    run_ctl.empty = item_eos_r && (run_len == '0);
    if (run_ctl.empty) begin
      run_bytes = '0;
      run_len   = RUN_W'(1);
    end
    run_load = advance && (run_len != '0);

    win_nxt = win_app >> {rel, 3'b000};
    cnt_nxt = (full_hit || item_eos_r) ? '0 : (cnt_app - rel);
  end

  // window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (advance) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      win_r <= win_nxt;
    end
  end

  sfr_out #(
    .RUN_MAX (RUN_MAX),
    .RUN_W   (RUN_W)
  ) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (run_load),
    .load_bytes (run_bytes),
    .load_len   (run_len),
    .load_ctl   (run_ctl),
    .run_free   (run_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== src/sfr_checker.sv =====
// sfr_checker: port-level checks of the output stream of stream_find_replace
// bound to the top level below; no package dependencies

module sfr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic [1:0] out_tuser
);

  // output is idle right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // string done only closes a run
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> out_tlast)
    else $error("string done on a beat that is not last of run");

  // a beat without data is the lone end marker
  a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tlast && out_tuser[1] && out_tdata == 8'h00))
    else $error("empty beat that is not a clean end marker");

  // stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser)))
    else $error("output beat changed while stalled");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (.*);
